/* sv/fir_pkg.sv */
// shared constants, types and control struct for the bit-serial fir filter
// no dependencies; imported by every module of the block

package fir_pkg;

    // filter geometry
    localparam int TAPS       = 8;
    localparam int MAX_TAPS   = 8;
    localparam int HIST_DEPTH = MAX_TAPS - 1;
    localparam int TAP_IDX_W  = $clog2(MAX_TAPS);

    // field widths
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int BIT_CNT_W  = $clog2(SAMPLE_W);
    localparam int CFG_ADDR_W = 8;

    // accumulator geometry: partial sums of gated coefficients and the upper accumulator half
    localparam int PAIR_W     = COEF_W + 1;
    localparam int PSUM_W     = COEF_W + 3;
    localparam int SUM_W      = PSUM_W + 2;
    localparam int ACC_HI_W   = SUM_W - 1;
    localparam int Q_W        = ACC_HI_W + 2;

    localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(SAMPLE_W - 1);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef t_coef                      t_coef_arr [MAX_TAPS];
    typedef logic [MAX_TAPS-1:0]        t_tap_bits;

    // per-cycle control for the serial multiply-accumulate
    typedef struct packed {
        logic valid;   // a bit slice is on the tap bit lines
        logic first;   // least significant bit of the samples
        logic last;    // sign bit of the samples, weighted negative
    } t_mac_ctrl;

endpackage

/* sv/fir_filter_16bit.sv */
// top level of the bit-serial direct-form fir filter: coefficient registers,
// sequencer and output register; depends on fir_pkg, fir_tap_shift, fir_bit_mac

// One sample is accepted when the block is idle and gives one filtered sample.
// The sample and the seven previous ones are consumed one bit per cycle, least
// significant bit first; an item passes from acceptance through the bit-serial
// steps over the sample word, the second stage of the coefficient adder tree,
// rounding and saturation and the load of the output register. The input is
// ready again in the following cycle, so a sample is taken only once the last
// one has reached the output register. A new sample is taken while a finished
// result still waits on the output side; if that result is still not taken when
// the next one is done, the sequencer holds until the output register frees.
// Coefficients are Q1.15 and are written through the cfg channel (index 0 is the
// newest tap); writes at indexes past the last tap are ignored. The delay line
// clears at reset.

module fir_filter_16bit
    import fir_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [SAMPLE_W-1:0]   i_s_axis_tdata,   // [15:0] sample_in
    // output stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [SAMPLE_W-1:0]   o_m_axis_tdata,   // [15:0] sample_out
    // coefficient writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [COEF_W-1:0]     i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_HOLD
    } t_state;

    t_state               r_state;
    t_state               n_state;
    logic [BIT_CNT_W-1:0] r_cnt;
    logic [BIT_CNT_W-1:0] n_cnt;
    t_coef_arr            r_coef;

    logic      in_beat;
    logic      out_free;
    logic      out_load;
    logic      q_valid;
    t_sample   q;
    t_tap_bits tap_bits;
    t_mac_ctrl mac_ctrl;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_beat         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !o_m_axis_tvalid || i_m_axis_tready;

    // coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < MAX_TAPS; t++) begin
                r_coef[t] <= '0;
            end
        end else if (i_cfg_valid && (i_cfg_addr < CFG_ADDR_W'(MAX_TAPS))) begin
            r_coef[i_cfg_addr[TAP_IDX_W-1:0]] <= i_cfg_data;
        end
    end

    // sequencer next state
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_state = S_RUN;
                    n_cnt   = '0;
                end
            end
            S_RUN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_BIT) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (q_valid) begin
                    if (out_free) begin
                        out_load = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_state = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state, counter and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_cnt           <= '0;
            o_m_axis_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (out_load) begin
                o_m_axis_tvalid <= 1'b1;
                o_m_axis_tdata  <= q;
            end else if (i_m_axis_tready) begin
                o_m_axis_tvalid <= 1'b0;
            end
        end
    end

    // one bit slice per run cycle
    always_comb begin
        mac_ctrl.valid = (r_state == S_RUN);
        mac_ctrl.first = (r_state == S_RUN) && (r_cnt == '0);
        mac_ctrl.last  = (r_state == S_RUN) && (r_cnt == LAST_BIT);
    end

    fir_tap_shift u_taps (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (in_beat),
        .i_sample (i_s_axis_tdata),
        .i_shift  (mac_ctrl.valid),
        .o_bits   (tap_bits)
    );

    fir_bit_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (mac_ctrl),
        .i_bits    (tap_bits),
        .i_coef    (r_coef),
        .o_q_valid (q_valid),
        .o_q       (q)
    );

    // a finished result only shows up while the sequencer waits for it
    a_q_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_valid |-> (r_state == S_DRAIN))
        else $error("mac result outside drain");

    // an accepted sample starts the bit count from zero
    a_start_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> (r_state == S_RUN) && (r_cnt == '0))
        else $error("run did not start after accept");

    // the sign bit step ends the run
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) && (r_cnt == LAST_BIT) |=> (r_state == S_DRAIN))
        else $error("run did not end after sign bit");

    // the output register is never overwritten while a beat waits
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("output beat overwritten");

endmodule

/* sv/fir_tap_shift.sv */
// delay line of past samples and the bit-serial shift registers fed to the mac
// depends on fir_pkg

module fir_tap_shift
    import fir_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_sample   i_sample,
    input  logic      i_shift,
    output t_tap_bits o_bits
);

    t_sample r_delay [HIST_DEPTH];
    t_sample r_work  [MAX_TAPS];

    // delay line, newest first, cleared so the stream starts from silence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
                r_delay[i] <= '0;
            end
        end else if (i_load) begin
            r_delay[0] <= i_sample;
            for (int i = 1; i < HIST_DEPTH; i++) begin
                r_delay[i] <= r_delay[i-1];
            end
        end
    end

    // working copies shift out one bit per cycle while i_shift is high, lsb first
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_work[0] <= i_sample;
            for (int t = 1; t < MAX_TAPS; t++) begin
                r_work[t] <= r_delay[t-1];
            end
        end else if (i_shift) begin
            for (int t = 0; t < MAX_TAPS; t++) begin
                r_work[t] <= {r_work[t][SAMPLE_W-1], r_work[t][SAMPLE_W-1:1]};
            end
        end
    end

    // current bit slice across all taps
    always_comb begin
        for (int t = 0; t < MAX_TAPS; t++) begin
            o_bits[t] = r_work[t][0];
        end
    end

endmodule

/* sv/fir_bit_mac.sv */
// serial-parallel multiply-accumulate: one sample bit of every tap per valid cycle,
// then truncation toward zero by 2^15 and saturation; depends on fir_pkg

module fir_bit_mac
    import fir_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_mac_ctrl i_ctrl,
    input  t_tap_bits i_bits,
    input  t_coef_arr i_coef,
    output logic      o_q_valid,
    output t_sample   o_q
);

    t_coef                    g [MAX_TAPS];
    logic signed [PAIR_W-1:0] r_pair [MAX_TAPS/2];
    t_mac_ctrl                r_ctrl_a;

    logic signed [PSUM_W-1:0]   p_sum;
    logic signed [SUM_W-1:0]    term;
    logic signed [SUM_W-1:0]    base;
    logic signed [SUM_W-1:0]    n_sum;
    logic signed [ACC_HI_W-1:0] r_acc_hi;
    logic [SAMPLE_W-1:0]        r_acc_lo;
    logic                       r_done;

    logic signed [Q_W-1:0] q_floor;
    logic signed [Q_W-1:0] q_trunc;
    logic                  q_round;
    t_sample               n_q;

    // gate coefficients by the sample bits, taps past the filter length drop out
    always_comb begin
        for (int t = 0; t < MAX_TAPS; t++) begin
            g[t] = (i_bits[t] && (t < TAPS)) ? i_coef[t] : '0;
        end
    end

    // stage a: pairwise sums
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_TAPS/2; k++) begin
            r_pair[k] <= {g[2*k][COEF_W-1], g[2*k]} + {g[2*k+1][COEF_W-1], g[2*k+1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_a <= '0;
        end else begin
            r_ctrl_a <= i_ctrl;
        end
    end

    // stage b: finish the tree and fold into the shifting accumulator
    always_comb begin
        p_sum = '0;
        for (int k = 0; k < MAX_TAPS/2; k++) begin
            p_sum = p_sum + {{(PSUM_W-PAIR_W){r_pair[k][PAIR_W-1]}}, r_pair[k]};
        end
        term  = {{(SUM_W-PSUM_W){p_sum[PSUM_W-1]}}, p_sum};
        if (r_ctrl_a.last) begin
            term = -term;
        end
        base  = r_ctrl_a.first ? '0 : {r_acc_hi[ACC_HI_W-1], r_acc_hi};
        n_sum = base + term;
    end

    always_ff @(posedge i_clk) begin
        if (r_ctrl_a.valid) begin
            r_acc_hi <= n_sum[SUM_W-1:1];
            r_acc_lo <= {n_sum[0], r_acc_lo[SAMPLE_W-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_ctrl_a.valid && r_ctrl_a.last;
        end
    end

    // stage c: divide by 2^15 toward zero, then clamp to 16 bits
    always_comb begin
        q_floor = {r_acc_hi[ACC_HI_W-1], r_acc_hi, r_acc_lo[SAMPLE_W-1]};
        q_round = r_acc_hi[ACC_HI_W-1] && (|r_acc_lo[SAMPLE_W-2:0]);
        q_trunc = q_floor + {{(Q_W-1){1'b0}}, q_round};
        if (q_trunc > Q_W'(32767)) begin
            n_q = 16'sh7FFF;
        end else if (q_trunc < -Q_W'(32768)) begin
            n_q = 16'sh8000;
        end else begin
            n_q = q_trunc[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_done) begin
            o_q <= n_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_q_valid <= 1'b0;
        end else begin
            o_q_valid <= r_done;
        end
    end

endmodule

/* tb/sv/tb_fir_filter_16bit.sv */
`timescale 1ns / 1ps
// self-checking testbench for fir_filter_16bit: a directed table, then random phases
// of coefficient settings and sample streams, checked against an in-bench filter or typed results
// depends on fir_pkg and the fir_filter_16bit rtl

module tb_fir_filter_16bit;
    import fir_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RANDOM_ITEMS = 1850;
    localparam int IDLE_LIMIT   = 3000;
    localparam int TAIL_CYCLES  = 40;
    localparam int REPORT_MAX   = 10;
    localparam int DIR_ROWS     = 37;

    typedef enum logic [1:0] {ROW_COEF, ROW_SAMPLE, ROW_SAMPLE_KNOWN} t_row_kind;
    typedef enum logic [2:0] {
        COEF_RANDOM, COEF_EXTREME, COEF_SMALL, COEF_SINGLE, COEF_ZERO
    } t_coef_mode;
    typedef enum logic [1:0] {SMP_FULL, SMP_EXTREME, SMP_SMALL, SMP_SQUARE} t_sample_mode;
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PATTERN, RX_STARVE} t_rx_mode;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_ADDR_W-1:0] addr;
        logic [15:0]           data;   // coefficient or sample
        logic [15:0]           known;  // typed result for ROW_SAMPLE_KNOWN
    } t_row;

    // dut ports
    logic                  i_clk;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [SAMPLE_W-1:0]   i_s_axis_tdata  = '0;   // [15:0] sample_in
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [SAMPLE_W-1:0]   o_m_axis_tdata;         // [15:0] sample_out
    logic                  i_cfg_valid     = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_ADDR_W-1:0] i_cfg_addr      = '0;
    logic [COEF_W-1:0]     i_cfg_data      = '0;

    // filter shadow state and scoreboard
    t_coef       coef_shadow [MAX_TAPS];
    t_sample     history [HIST_DEPTH];
    t_sample     expected_out [$];
    t_sample     out_want;
    int unsigned fail_count   = 0;
    int unsigned outputs_seen = 0;
    int unsigned samples_sent = 0;
    int unsigned coef_writes  = 0;
    int unsigned phases       = 0;
    int unsigned burst_left   = 0;
    int unsigned idle_cycles  = 0;
    int unsigned rx_left      = 0;
    t_rx_mode    rx_mode      = RX_OPEN;

    // directed rows: reset state, saturation both ways, truncation of small negatives,
    // writes past the last tap
    t_row directed_rows [DIR_ROWS] = '{
        '{ROW_SAMPLE_KNOWN, 8'd0,   16'h7FFF, 16'h0000},
        '{ROW_SAMPLE_KNOWN, 8'd0,   16'h8000, 16'h0000},
        '{ROW_COEF,         8'd0,   16'h8000, 16'h0000},
        '{ROW_SAMPLE_KNOWN, 8'd0,   16'h8000, 16'h7FFF},
        '{ROW_SAMPLE_KNOWN, 8'd0,   16'h7FFF, 16'h8001},
        '{ROW_COEF,         8'd0,   16'h0001, 16'h0000},
        '{ROW_SAMPLE_KNOWN, 8'd0,   16'hFFFF, 16'h0000},
        '{ROW_SAMPLE_KNOWN, 8'd0,   16'h0001, 16'h0000},
        '{ROW_COEF,         8'd0,   16'h7FFF, 16'h0000},
        '{ROW_COEF,         8'd1,   16'h7FFF, 16'h0000},
        '{ROW_COEF,         8'd2,   16'h7FFF, 16'h0000},
        '{ROW_COEF,         8'd3,   16'h7FFF, 16'h0000},
        '{ROW_COEF,         8'd4,   16'h7FFF, 16'h0000},
        '{ROW_COEF,         8'd5,   16'h7FFF, 16'h0000},
        '{ROW_COEF,         8'd6,   16'h7FFF, 16'h0000},
        '{ROW_COEF,         8'd7,   16'h7FFF, 16'h0000},
        '{ROW_SAMPLE,       8'd0,   16'h7FFF, 16'h0000},
        '{ROW_SAMPLE,       8'd0,   16'h7FFF, 16'h0000},
        '{ROW_SAMPLE,       8'd0,   16'h7FFF, 16'h0000},
        '{ROW_SAMPLE,       8'd0,   16'h7FFF, 16'h0000},
        '{ROW_SAMPLE,       8'd0,   16'h7FFF, 16'h0000},
        '{ROW_SAMPLE,       8'd0,   16'h7FFF, 16'h0000},
        '{ROW_SAMPLE,       8'd0,   16'h7FFF, 16'h0000},
        '{ROW_SAMPLE_KNOWN, 8'd0,   16'h7FFF, 16'h7FFF},
        '{ROW_SAMPLE,       8'd0,   16'h8000, 16'h0000},
        '{ROW_SAMPLE,       8'd0,   16'h8000, 16'h0000},
        '{ROW_SAMPLE,       8'd0,   16'h8000, 16'h0000},
        '{ROW_SAMPLE,       8'd0,   16'h8000, 16'h0000},
        '{ROW_SAMPLE,       8'd0,   16'h8000, 16'h0000},
        '{ROW_SAMPLE,       8'd0,   16'h8000, 16'h0000},
        '{ROW_SAMPLE,       8'd0,   16'h8000, 16'h0000},
        '{ROW_SAMPLE_KNOWN, 8'd0,   16'h8000, 16'h8000},
        '{ROW_COEF,         8'd8,   16'h1234, 16'h0000},
        '{ROW_COEF,         8'hFF,  16'hFFFF, 16'h0000},
        '{ROW_COEF,         8'd3,   16'h8000, 16'h0000},
        '{ROW_SAMPLE,       8'd0,   16'h5A5A, 16'h0000},
        '{ROW_SAMPLE,       8'd0,   16'hA5A5, 16'h0000}
    };

    fir_filter_16bit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // shift a sample into the shadow delay line and return the filtered value
    function automatic t_sample filtered_sample(input t_sample newest);
        longint acc;
        longint q;
        acc = 0;
        for (int t = 0; t < TAPS; t++) begin
            acc += longint'(coef_shadow[t]) * longint'(t == 0 ? newest : history[t-1]);
        end
        // divide by 2^15 toward zero, then clamp to 16 bits
        if (acc < 0) begin
            q = -((-acc) >>> 15);
        end else begin
            q = acc >>> 15;
        end
        if (q > 32767) begin
            q = 32767;
        end
        if (q < -32768) begin
            q = -32768;
        end
        for (int t = HIST_DEPTH - 1; t > 0; t--) begin
            history[t] = history[t-1];
        end
        history[0] = newest;
        return t_sample'(q);
    endfunction

    // coefficient write, only once every pending result has drained
    task automatic write_coef(input logic [CFG_ADDR_W-1:0] addr, input logic [COEF_W-1:0] data);
        i_s_axis_tvalid <= 1'b0;
        while (expected_out.size() != 0) begin
            @(posedge i_clk);
        end
        i_cfg_valid     <= 1'b1;
        i_cfg_addr      <= addr;
        i_cfg_data      <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (addr < MAX_TAPS) begin
            coef_shadow[addr[TAP_IDX_W-1:0]] = t_coef'(data);
        end
        coef_writes++;
    endtask

    // one input beat, sent in bursts with random gaps between them
    task automatic send_sample(input t_sample value, input logic use_known, input t_sample known);
        int unsigned gap;
        t_sample     want;
        i_cfg_valid <= 1'b0;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) == 0) begin
                gap        = 0;
                burst_left = $urandom_range(40, 200);
            end else begin
                gap        = $urandom_range(1, 30);
                burst_left = $urandom_range(1, 12);
            end
            if (gap != 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= value;
        do @(posedge i_clk); while (!o_s_axis_tready);
        want = filtered_sample(value);
        expected_out.push_back(use_known ? known : want);
        burst_left--;
        samples_sent++;
    endtask

    // receiver stall pattern, in modes picked at random for runs of random length
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(50, 400);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:    i_m_axis_tready <= 1'b1;
            RX_COIN:    i_m_axis_tready <= 1'($urandom_range(0, 1));
            RX_PATTERN: i_m_axis_tready <= (rx_left % 11) < 4;
            default:    i_m_axis_tready <= ($urandom_range(0, 11) == 0);
        endcase
    end

    // output beat check against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_out.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX) begin
                    $display("unexpected output beat: sample_out %h", o_m_axis_tdata);
                end
            end else begin
                out_want = expected_out.pop_front();
                if (o_m_axis_tdata !== out_want) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX) begin
                        $display("output %0d: sample_out expected %h got %h",
                                 outputs_seen, out_want, o_m_axis_tdata);
                    end
                end
                outputs_seen++;
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
            $display("tb_fir_filter_16bit: FAIL");
            $finish;
        end
    end

    // stimulus
    initial begin : stimulus
        t_coef_mode   cmode;
        t_sample_mode smode;
        int unsigned  phase_len;
        int unsigned  single_tap;
        int unsigned  random_start;
        t_coef        c;
        t_sample      s;

        for (int t = 0; t < MAX_TAPS; t++) begin
            coef_shadow[t] = '0;
        end
        for (int t = 0; t < HIST_DEPTH; t++) begin
            history[t] = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (directed_rows[r]) begin
            case (directed_rows[r].kind)
                ROW_COEF:   write_coef(directed_rows[r].addr, directed_rows[r].data);
                ROW_SAMPLE: send_sample(directed_rows[r].data, 1'b0, '0);
                default:    send_sample(directed_rows[r].data, 1'b1, directed_rows[r].known);
            endcase
        end

        // random phases: a coefficient set, then a stream of samples
        random_start = samples_sent;
        while (samples_sent - random_start < RANDOM_ITEMS) begin
            cmode      = (phases == 0) ? COEF_EXTREME : t_coef_mode'($urandom_range(0, 4));
            single_tap = $urandom_range(0, MAX_TAPS - 1);
            for (int t = 0; t < MAX_TAPS; t++) begin
                case (cmode)
                    COEF_RANDOM:  c = t_coef'($urandom);
                    COEF_EXTREME: c = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                    COEF_SMALL:   c = t_coef'(int'($urandom_range(0, 512)) - 256);
                    COEF_SINGLE:  c = (t == single_tap) ? t_coef'($urandom) : '0;
                    default:      c = '0;
                endcase
                write_coef(CFG_ADDR_W'(t), c);
            end
            // occasional write past the last tap, which must leave the taps alone
            if ($urandom_range(0, 2) == 0) begin
                write_coef(CFG_ADDR_W'($urandom_range(MAX_TAPS, (1 << CFG_ADDR_W) - 1)),
                           COEF_W'($urandom));
            end
            smode     = t_sample_mode'($urandom_range(0, 3));
            phase_len = $urandom_range(60, 160);
            for (int n = 0; (n < phase_len) && (samples_sent - random_start < RANDOM_ITEMS);
                 n++) begin
                case (smode)
                    SMP_FULL: s = t_sample'($urandom);
                    SMP_EXTREME: begin
                        case ($urandom_range(0, 3))
                            0:       s = 16'sh7FFF;
                            1:       s = 16'sh8000;
                            2:       s = 16'sh0000;
                            default: s = 16'shFFFF;
                        endcase
                    end
                    SMP_SMALL: s = t_sample'(int'($urandom_range(0, 128)) - 64);
                    default:   s = ((n % 8) < 4) ? 16'sh7FFF : 16'sh8000;
                endcase
                send_sample(s, 1'b0, '0);
            end
            phases++;
        end

        // drain and close
        i_s_axis_tvalid <= 1'b0;
        i_cfg_valid     <= 1'b0;
        while (expected_out.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("run covered %0d samples over %0d random coefficient phases, %0d register writes",
                 samples_sent, phases, coef_writes);
        $display("%0d filtered samples checked, %0d failures", outputs_seen, fail_count);
        if (fail_count == 0) begin
            $display("tb_fir_filter_16bit: PASS");
        end else begin
            $display("tb_fir_filter_16bit: FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/fir_pkg.sv
sv/fir_tap_shift.sv
sv/fir_bit_mac.sv
sv/fir_filter_16bit.sv
tb/sv/tb_fir_filter_16bit.sv
